/* design/sswv_pkg.sv */
// Shared types and constants for the sparse set with values.
// No dependencies; imported by sswv_ctrl, the top level and the bench.
`default_nettype none

package sswv_pkg;

    // Default sizing handed to the top-level parameters
    localparam int DEF_INDEX_RANGE = 1024;
    localparam int DEF_VALUE_WIDTH = 32;

    // Fixed field widths of the stream payloads
    localparam int OP_W   = 3;
    localparam int KEY_W  = 10;
    localparam int DATA_W = 32;
    localparam int POS_W  = 10;
    localparam int CNT_W  = 11;

    // Packed stream widths, tdata rounded up to whole bytes
    localparam int S_TDATA_W = 56;
    localparam int S_TUSER_W = OP_W;
    localparam int M_TDATA_W = 64;
    localparam int M_TUSER_W = 1;

    // Operation codes
    typedef enum logic [OP_W-1:0] {
        OP_LOOKUP    = 3'd0,
        OP_EMPLACE   = 3'd1,
        OP_SET_VALUE = 3'd2,
        OP_ERASE     = 3'd3,
        OP_CLEAR     = 3'd4,
        OP_READ_SLOT = 3'd5
    } t_opcode;

    // One result item, passed from the sequencer to the output stage
    typedef struct packed {
        logic              found;
        logic [KEY_W-1:0]  key;
        logic [DATA_W-1:0] value;
        logic [POS_W-1:0]  slot;
        logic [CNT_W-1:0]  count;
    } t_result;

endpackage

`default_nettype wire

/* design/sswv_ram.sv */
// Simple dual-port synchronous RAM: one write port, one read port,
// registered read data (old data on a same-address write).
`default_nettype none

module sswv_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

/* design/sswv_ctrl.sv */
// Operation sequencer: owns the key map and the dense key/value lists,
// runs read-modify-write per operation, the clear walk and the reset sweep.
// Depends on sswv_pkg and sswv_ram.
`default_nettype none

module sswv_ctrl #(
    parameter int INDEX_RANGE = sswv_pkg::DEF_INDEX_RANGE,
    parameter int VALUE_WIDTH = sswv_pkg::DEF_VALUE_WIDTH
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_valid,
    output logic                                 o_ready,
    input  wire logic [sswv_pkg::OP_W-1:0]       i_op,
    input  wire logic [sswv_pkg::KEY_W-1:0]      i_key,
    input  wire logic [sswv_pkg::DATA_W-1:0]     i_data,
    input  wire logic [sswv_pkg::POS_W-1:0]      i_pos,
    input  wire logic                            i_out_free,
    output logic                                 o_fire,
    output sswv_pkg::t_result                    o_res
);

    import sswv_pkg::*;

    localparam int SLW  = $clog2(INDEX_RANGE);
    localparam int CW   = $clog2(INDEX_RANGE + 1);
    localparam int SW   = (VALUE_WIDTH < DATA_W) ? VALUE_WIDTH : DATA_W;
    localparam int MAPW = SLW + 1;

    typedef enum logic [6:0] {
        S_INIT  = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_MAP   = 7'b0000100,
        S_DENSE = 7'b0001000,
        S_FIX   = 7'b0010000,
        S_CLR   = 7'b0100000,
        S_WAIT  = 7'b1000000
    } t_state;

    t_state            r_state, n_state;
    logic [OP_W-1:0]   r_op, n_op;
    logic [KEY_W-1:0]  r_key, n_key;
    logic [SW-1:0]     r_data, n_data;
    logic [POS_W-1:0]  r_pos, n_pos;
    logic [CW-1:0]     r_count, n_count;
    logic [SLW-1:0]    r_slot, n_slot;
    logic [SLW-1:0]    r_init_addr, n_init_addr;
    logic              r_clr_pend, n_clr_pend;
    t_result           r_res, n_res;

    // Memory ports
    logic              map_we;
    logic [SLW-1:0]    map_waddr, map_raddr;
    logic [MAPW-1:0]   map_wdata, map_rdata;
    logic              dk_we;
    logic [SLW-1:0]    dk_waddr, dk_raddr, dk_wdata, dk_rdata;
    logic              dv_we;
    logic [SLW-1:0]    dv_waddr, dv_raddr;
    logic [SW-1:0]     dv_wdata, dv_rdata;

    logic              accept;
    logic              key_ok;
    logic              present;
    logic [SLW-1:0]    map_slot;
    logic              fin;
    t_result           fin_res;

    // Map entry: valid bit on top, dense slot below
    sswv_ram #(.WIDTH(MAPW), .DEPTH(INDEX_RANGE)) u_map (
        .i_clk   (i_clk),
        .i_we    (map_we),
        .i_waddr (map_waddr),
        .i_wdata (map_wdata),
        .i_raddr (map_raddr),
        .o_rdata (map_rdata)
    );

    sswv_ram #(.WIDTH(SLW), .DEPTH(INDEX_RANGE)) u_dense_keys (
        .i_clk   (i_clk),
        .i_we    (dk_we),
        .i_waddr (dk_waddr),
        .i_wdata (dk_wdata),
        .i_raddr (dk_raddr),
        .o_rdata (dk_rdata)
    );

    sswv_ram #(.WIDTH(SW), .DEPTH(INDEX_RANGE)) u_dense_values (
        .i_clk   (i_clk),
        .i_we    (dv_we),
        .i_waddr (dv_waddr),
        .i_wdata (dv_wdata),
        .i_raddr (dv_raddr),
        .o_rdata (dv_rdata)
    );

    assign o_ready  = (r_state == S_IDLE);
    assign accept   = i_valid && o_ready;
    assign key_ok   = (32'(r_key) < 32'(INDEX_RANGE));
    assign present  = key_ok && map_rdata[SLW];
    assign map_slot = map_rdata[SLW-1:0];

    // Sequencer next state, memory accesses and result
    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_key       = r_key;
        n_data      = r_data;
        n_pos       = r_pos;
        n_count     = r_count;
        n_slot      = r_slot;
        n_init_addr = r_init_addr;
        n_clr_pend  = r_clr_pend;
        n_res       = r_res;

        map_we    = 1'b0;
        map_waddr = SLW'(r_key);
        map_wdata = '0;
        map_raddr = SLW'(r_key);
        dk_we     = 1'b0;
        dk_waddr  = r_slot;
        dk_wdata  = SLW'(r_key);
        dk_raddr  = SLW'(r_pos);
        dv_we     = 1'b0;
        dv_waddr  = r_slot;
        dv_wdata  = r_data;
        dv_raddr  = r_slot;

        fin     = 1'b0;
        fin_res = '0;
        o_fire  = 1'b0;
        o_res   = r_res;

        case (r_state)
            // Mark every key empty after reset
            S_INIT: begin
                map_we      = 1'b1;
                map_waddr   = r_init_addr;
                n_init_addr = r_init_addr + 1'b1;
                if (r_init_addr == SLW'(INDEX_RANGE - 1)) begin
                    n_state = S_IDLE;
                end
            end

            // Take the item, start the map read and the slot read
            S_IDLE: begin
                map_raddr = SLW'(i_key);
                dk_raddr  = SLW'(i_pos);
                dv_raddr  = SLW'(i_pos);
                if (accept) begin
                    n_op    = i_op;
                    n_key   = i_key;
                    n_data  = i_data[SW-1:0];
                    n_pos   = i_pos;
                    n_state = S_MAP;
                end
            end

            // Map entry is back: decide and write
            S_MAP: begin
                n_slot = map_slot;
                case (r_op)
                    OP_LOOKUP: begin
                        if (present) begin
                            dv_raddr = map_slot;
                            n_state  = S_DENSE;
                        end else begin
                            fin = 1'b1;
                        end
                    end
                    OP_EMPLACE, OP_SET_VALUE: begin
                        if (present) begin
                            if (r_op == OP_SET_VALUE) begin
                                dv_we         = 1'b1;
                                dv_waddr      = map_slot;
                                fin           = 1'b1;
                                fin_res.found = 1'b1;
                                fin_res.key   = r_key;
                                fin_res.value = DATA_W'(r_data);
                                fin_res.slot  = POS_W'(map_slot);
                            end else begin
                                dv_raddr = map_slot;
                                n_state  = S_DENSE;
                            end
                        end else if (!key_ok || r_count == CW'(INDEX_RANGE)) begin
                            fin = 1'b1;
                        end else begin
                            // Append a new dense entry
                            map_we        = 1'b1;
                            map_wdata     = {1'b1, SLW'(r_count)};
                            dk_we         = 1'b1;
                            dk_waddr      = SLW'(r_count);
                            dv_we         = 1'b1;
                            dv_waddr      = SLW'(r_count);
                            n_count       = r_count + 1'b1;
                            fin           = 1'b1;
                            fin_res.key   = r_key;
                            fin_res.value = DATA_W'(r_data);
                            fin_res.slot  = POS_W'(r_count);
                        end
                    end
                    OP_ERASE: begin
                        if (present) begin
                            // Fetch the last dense entry to fill the hole
                            dk_raddr = SLW'(r_count - 1'b1);
                            dv_raddr = SLW'(r_count - 1'b1);
                            n_state  = S_DENSE;
                        end else begin
                            fin = 1'b1;
                        end
                    end
                    OP_CLEAR: begin
                        n_clr_pend = 1'b0;
                        n_state    = S_CLR;
                    end
                    OP_READ_SLOT: begin
                        fin = 1'b1;
                        if (32'(r_pos) < 32'(r_count)) begin
                            fin_res.found = 1'b1;
                            fin_res.key   = KEY_W'(dk_rdata);
                            fin_res.value = DATA_W'(dv_rdata);
                            fin_res.slot  = r_pos;
                        end
                    end
                    default: begin
                        fin = 1'b1;
                    end
                endcase
            end

            // Dense data is back
            S_DENSE: begin
                if (r_op == OP_ERASE) begin
                    if (32'(dk_rdata) != 32'(r_key)) begin
                        dk_we     = 1'b1;
                        dk_wdata  = dk_rdata;
                        dv_we     = 1'b1;
                        dv_wdata  = dv_rdata;
                        map_we    = 1'b1;
                        map_waddr = dk_rdata;
                        map_wdata = {1'b1, r_slot};
                    end
                    n_count = r_count - 1'b1;
                    n_state = S_FIX;
                end else begin
                    fin           = 1'b1;
                    fin_res.found = 1'b1;
                    fin_res.key   = r_key;
                    fin_res.value = DATA_W'(dv_rdata);
                    fin_res.slot  = POS_W'(r_slot);
                end
            end

            // Erase: mark the erased key empty
            S_FIX: begin
                map_we        = 1'b1;
                fin           = 1'b1;
                fin_res.found = 1'b1;
                fin_res.key   = r_key;
                fin_res.slot  = POS_W'(r_slot);
            end

            // Clear walk: read a dense key, empty its map entry next cycle
            S_CLR: begin
                if (r_clr_pend) begin
                    map_we    = 1'b1;
                    map_waddr = dk_rdata;
                end
                if (r_count != '0) begin
                    dk_raddr   = SLW'(r_count - 1'b1);
                    n_count    = r_count - 1'b1;
                    n_clr_pend = 1'b1;
                end else begin
                    n_clr_pend = 1'b0;
                    if (!r_clr_pend) begin
                        fin = 1'b1;
                    end
                end
            end

            // Result held until the output register frees up
            S_WAIT: begin
                if (i_out_free) begin
                    o_fire  = 1'b1;
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Hand the result over now, or park it
        fin_res.count = CNT_W'(n_count);
        if (fin) begin
            if (i_out_free) begin
                o_fire  = 1'b1;
                o_res   = fin_res;
                n_state = S_IDLE;
            end else begin
                n_res   = fin_res;
                n_state = S_WAIT;
            end
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_count     <= '0;
            r_init_addr <= '0;
            r_clr_pend  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_init_addr <= n_init_addr;
            r_clr_pend  <= n_clr_pend;
        end
    end

    // Item payload
    always_ff @(posedge i_clk) begin
        r_op   <= n_op;
        r_key  <= n_key;
        r_data <= n_data;
        r_pos  <= n_pos;
        r_slot <= n_slot;
        r_res  <= n_res;
    end

endmodule

`default_nettype wire

/* design/sparse_set_with_values.sv */
// Sparse set of keys 0..INDEX_RANGE-1, each with one value, behind stream ports.
// One operation is in flight at a time. A map miss, a new emplace, a set value
// and a read slot finish once the key map entry is read; a lookup or emplace hit
// then reads the dense lists, an erase reads them and fixes the key map, and a
// clear walks the stored entries; each step waits on the registered read of the
// key map and then of the dense lists. A result that finds the output register
// still occupied waits in a hold state until m_axis_tready frees it. After reset
// the key map is cleared one entry per cycle, and s_axis_tready stays low until
// every entry is cleared. A finished result sits in the output register while
// the next item is taken.
// Depends on sswv_pkg and sswv_ctrl.
`default_nettype none

module sparse_set_with_values #(
    parameter int INDEX_RANGE = sswv_pkg::DEF_INDEX_RANGE,
    parameter int VALUE_WIDTH = sswv_pkg::DEF_VALUE_WIDTH
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_s_axis_tvalid,
    output logic                                   o_s_axis_tready,
    // key_index[9:0], data_value[41:10], slot_position[51:42], zero pad
    input  wire logic [sswv_pkg::S_TDATA_W-1:0]    i_s_axis_tdata,
    // opcode[2:0]
    input  wire logic [sswv_pkg::S_TUSER_W-1:0]    i_s_axis_tuser,
    output logic                                   o_m_axis_tvalid,
    input  wire logic                              i_m_axis_tready,
    // result_key[9:0], result_value[41:10], result_slot[51:42],
    // element_count[62:52], zero pad
    output logic      [sswv_pkg::M_TDATA_W-1:0]    o_m_axis_tdata,
    // found[0]
    output logic      [sswv_pkg::M_TUSER_W-1:0]    o_m_axis_tuser
);

    import sswv_pkg::*;

    logic    out_free;
    logic    w_fire;
    t_result w_res;
    logic    r_out_valid;
    t_result r_out;

    assign out_free = !r_out_valid || i_m_axis_tready;

    sswv_ctrl #(
        .INDEX_RANGE (INDEX_RANGE),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_s_axis_tvalid),
        .o_ready    (o_s_axis_tready),
        .i_op       (i_s_axis_tuser[OP_W-1:0]),
        .i_key      (i_s_axis_tdata[KEY_W-1:0]),
        .i_data     (i_s_axis_tdata[KEY_W+DATA_W-1:KEY_W]),
        .i_pos      (i_s_axis_tdata[KEY_W+DATA_W+POS_W-1:KEY_W+DATA_W]),
        .i_out_free (out_free),
        .o_fire     (w_fire),
        .o_res      (w_res)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out <= w_res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {1'b0, r_out.count, r_out.slot, r_out.value, r_out.key};
    assign o_m_axis_tuser  = r_out.found;

    // One item at a time: no accept on the cycle after an accept
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("input accepted on back-to-back cycles");

    // A result is only handed over when the output register can take it
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire |-> out_free)
        else $error("result overwrote a pending output");

    // Element count never exceeds the key range
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (32'(r_out.count) <= 32'(INDEX_RANGE)))
        else $error("element count beyond key range");

endmodule

`default_nettype wire

/* bench/tb_top.sv */
// Self-checking bench for sparse_set_with_values: drives operations on the input stream,
// predicts each result from a private copy of the set, and checks the output stream.
// Depends on sswv_pkg and the sparse_set_with_values RTL.
`timescale 1ns / 100ps

module tb_top;
    import sswv_pkg::*;

    localparam int KEYS       = 1024;
    localparam int STALL_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 20;

    // Opcodes the block treats as no-ops
    localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

    // Mirror of the set plus the queue of results still owed by the block
    class set_scoreboard;
        bit                key_present[KEYS];
        bit [KEY_W-1:0]    key_slot[KEYS];
        bit [KEY_W-1:0]    slot_key[KEYS];
        bit [DATA_W-1:0]   slot_value[KEYS];
        int unsigned       count;
        t_result           owed_results[$];
        int                errors;

        function new();
            foreach (key_present[i]) key_present[i] = 1'b0;
            count  = 0;
            errors = 0;
        endfunction

        function t_result make_result(bit found, bit [KEY_W-1:0] key,
                                      bit [DATA_W-1:0] value, bit [POS_W-1:0] slot);
            t_result r;
            r.found = found;
            r.key   = key;
            r.value = value;
            r.slot  = slot;
            r.count = count[CNT_W-1:0];
            return r;
        endfunction

        // Apply one accepted operation to the mirror and queue its result
        function void note_op(logic [OP_W-1:0] op, bit [KEY_W-1:0] key,
                              bit [DATA_W-1:0] data, bit [POS_W-1:0] pos);
            bit              present;
            bit [KEY_W-1:0]  slot;
            bit [KEY_W-1:0]  last_key;
            int unsigned     last;
            t_result         res;
            present = key_present[key];
            slot    = key_slot[key];
            res     = make_result(0, 0, 0, 0);
            case (op)
                OP_LOOKUP: begin
                    if (present) res = make_result(1, key, slot_value[slot], slot);
                end
                OP_EMPLACE, OP_SET_VALUE: begin
                    if (!present && count >= KEYS) begin
                        res = make_result(0, 0, 0, 0);
                    end else begin
                        if (!present) begin
                            slot              = count[KEY_W-1:0];
                            key_present[key]  = 1'b1;
                            key_slot[key]     = slot;
                            slot_key[slot]    = key;
                            slot_value[slot]  = data;
                            count++;
                        end
                        if (op == OP_SET_VALUE) slot_value[slot] = data;
                        res = make_result(present, key, slot_value[slot], slot);
                    end
                end
                OP_ERASE: begin
                    if (present) begin
                        // last entry fills the hole unless it is the erased key itself
                        last     = count - 1;
                        last_key = slot_key[last];
                        if (last_key != key) begin
                            slot_key[slot]     = last_key;
                            slot_value[slot]   = slot_value[last];
                            key_slot[last_key] = slot;
                        end
                        key_present[key] = 1'b0;
                        count            = last;
                        res = make_result(1, key, 0, slot);
                    end
                end
                OP_CLEAR: begin
                    while (count > 0) begin
                        count--;
                        key_present[slot_key[count]] = 1'b0;
                    end
                    res = make_result(0, 0, 0, 0);
                end
                OP_READ_SLOT: begin
                    if (pos < count) res = make_result(1, slot_key[pos], slot_value[pos], pos);
                end
                default: res = make_result(0, 0, 0, 0);
            endcase
            owed_results.push_back(res);
        endfunction

        task flag_mismatch(string what, longint unsigned got, longint unsigned want);
            $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what,
                     got, want);
            errors++;
        endtask

        // Compare one transfer from the output stream with the oldest owed result
        task check_result(t_result got);
            t_result want;
            if (owed_results.size() == 0) begin
                flag_mismatch("unexpected result key", got.key, 0);
            end else begin
                want = owed_results.pop_front();
                if (got.found !== want.found) flag_mismatch("found", got.found, want.found);
                if (got.key !== want.key)     flag_mismatch("result_key", got.key, want.key);
                if (got.value !== want.value) flag_mismatch("result_value", got.value, want.value);
                if (got.slot !== want.slot)   flag_mismatch("result_slot", got.slot, want.slot);
                if (got.count !== want.count) flag_mismatch("element_count", got.count, want.count);
            end
        endtask
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_s_axis_tvalid;
    logic                  o_s_axis_tready;
    logic [S_TDATA_W-1:0]  i_s_axis_tdata;   // key_index[9:0], data_value[41:10], slot_position[51:42]
    logic [S_TUSER_W-1:0]  i_s_axis_tuser;   // opcode[2:0]
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready;
    logic [M_TDATA_W-1:0]  o_m_axis_tdata;   // result_key[9:0], result_value[41:10],
                                             // result_slot[51:42], element_count[62:52]
    logic [M_TUSER_W-1:0]  o_m_axis_tuser;   // found[0]

    set_scoreboard board = new();
    bit            steady = 1'b0;      // no idling on either side while set
    int            key_pool[24];
    int unsigned   quiet_cycles = 0;

    sparse_set_with_values dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Receiver backpressure, about a quarter of the cycles
    always @(negedge i_clk) begin
        i_m_axis_tready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 25);
    end

    // Output stream check
    always @(posedge i_clk) begin
        t_result got;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got.found = o_m_axis_tuser[0];
            got.key   = o_m_axis_tdata[9:0];
            got.value = o_m_axis_tdata[41:10];
            got.slot  = o_m_axis_tdata[51:42];
            got.count = o_m_axis_tdata[62:52];
            board.check_result(got);
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("tb_top: done, errors");
                $finish;
            end
        end
    end

    // Present one operation, with random gaps ahead of it, until it is taken
    task automatic send_op(logic [OP_W-1:0] op, bit [KEY_W-1:0] key,
                           bit [DATA_W-1:0] data, bit [POS_W-1:0] pos);
        @(negedge i_clk);
        while (!steady && $urandom_range(0, 99) < 25) begin
            i_s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {4'b0, pos, data, key};
        i_s_axis_tuser  <= op;
        do @(posedge i_clk); while (!(i_s_axis_tvalid && o_s_axis_tready));
        board.note_op(op, key, data, pos);
    endtask

    // Stop sending and wait for every owed result
    task automatic drain_results();
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        while (board.owed_results.size() > 0) @(negedge i_clk);
    endtask

    function automatic bit [KEY_W-1:0] pick_key();
        if ($urandom_range(0, 99) < 80) return KEY_W'(key_pool[$urandom_range(0, 23)]);
        return KEY_W'($urandom_range(0, KEYS - 1));
    endfunction

    // Mostly hits on a small key pool, with a few clears and spare opcodes
    task automatic run_random(int n_ops);
        int               r;
        logic [OP_W-1:0]  op;
        bit [POS_W-1:0]   pos;
        int unsigned      top;
        foreach (key_pool[i]) key_pool[i] = $urandom_range(0, KEYS - 1);
        for (int i = 0; i < n_ops; i++) begin
            r = $urandom_range(0, 99);
            if (r < 20)      op = OP_LOOKUP;
            else if (r < 40) op = OP_EMPLACE;
            else if (r < 55) op = OP_SET_VALUE;
            else if (r < 75) op = OP_ERASE;
            else if (r < 93) op = OP_READ_SLOT;
            else if (r < 95) op = OP_CLEAR;
            else if (r < 97) op = OP_SPARE_6;
            else             op = OP_SPARE_7;
            top = (board.count + 1 > KEYS - 1) ? KEYS - 1 : board.count + 1;
            pos = ($urandom_range(0, 99) < 75) ? POS_W'($urandom_range(0, top))
                                               : POS_W'($urandom_range(0, KEYS - 1));
            send_op(op, pick_key(), $urandom, pos);
        end
    endtask

    // Put every key in the set, then work on the full set and clear it
    task automatic fill_and_clear();
        int order[KEYS];
        int j;
        int t;
        foreach (order[i]) order[i] = i;
        for (int i = KEYS - 1; i > 0; i--) begin
            j        = $urandom_range(0, i);
            t        = order[i];
            order[i] = order[j];
            order[j] = t;
        end
        foreach (order[i]) send_op(OP_EMPLACE, KEY_W'(order[i]), $urandom, '0);
        send_op(OP_READ_SLOT, '0, '0, POS_W'(KEYS - 1));
        send_op(OP_EMPLACE, KEY_W'(order[7]), $urandom, '0);
        send_op(OP_SET_VALUE, KEY_W'(order[9]), $urandom, '0);
        send_op(OP_CLEAR, '0, '0, '0);
        send_op(OP_LOOKUP, KEY_W'(order[0]), '0, '0);
    endtask

    initial begin
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tuser  = '0;
        i_m_axis_tready = 1'b0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty set, field extremes, both erase paths, spare opcodes
        send_op(OP_LOOKUP, 0, 0, 0);
        send_op(OP_ERASE, 1023, 32'hFFFF_FFFF, 0);
        send_op(OP_READ_SLOT, 0, 0, 0);
        send_op(OP_EMPLACE, 0, 32'h0, 0);
        send_op(OP_EMPLACE, 1023, 32'hFFFF_FFFF, 1023);
        send_op(OP_EMPLACE, 0, 32'h5555_5555, 0);          // hit keeps old value
        send_op(OP_SET_VALUE, 0, 32'hAAAA_AAAA, 0);        // hit overwrites
        send_op(OP_SET_VALUE, 512, 32'h1234_5678, 0);      // miss appends
        send_op(OP_LOOKUP, 1023, 0, 0);
        send_op(OP_READ_SLOT, 0, 0, 0);
        send_op(OP_READ_SLOT, 0, 0, 1);
        send_op(OP_READ_SLOT, 0, 0, 2);
        send_op(OP_READ_SLOT, 0, 0, 3);                    // past the count
        send_op(OP_READ_SLOT, 1023, 32'hFFFF_FFFF, 1023);
        send_op(OP_ERASE, 0, 0, 0);                        // last entry moves down
        send_op(OP_ERASE, 1023, 0, 0);                     // erased key is the last one
        send_op(OP_LOOKUP, 512, 0, 0);
        send_op(OP_SPARE_6, 512, 32'hFFFF_FFFF, 1023);
        send_op(OP_SPARE_7, 1023, 32'hFFFF_FFFF, 1023);
        send_op(OP_EMPLACE, 700, 32'hDEAD_BEEF, 0);
        send_op(OP_CLEAR, 0, 0, 0);
        send_op(OP_LOOKUP, 512, 0, 0);
        send_op(OP_EMPLACE, 5, 32'h0000_0001, 0);
        drain_results();

        run_random(80);
        drain_results();

        steady = 1'b1;
        fill_and_clear();
        steady = 1'b0;

        run_random(80);
        drain_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (board.errors == 0 && board.owed_results.size() == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule
